// ===== hw/rtl/setb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setb_pkg: shared types and codes for the sorted expiry timer table
// Operation codes, status codes and the channel payload structs.
// ----------------------------------------------------------------------------
package setb_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_TICK   = 2'd2,
    OP_DUMP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_TMO   = 2'd1,
    ST_DUP_POS   = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_TIMER  = 1'b1;

  typedef struct packed {
    logic [1:0]         operation;
    logic [11:0]        position;
    logic signed [31:0] timeout_ms;
    logic signed [31:0] start_elapsed_ms;
    logic [15:0]        tick_delta_ms;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [1:0]         status;
    logic [11:0]        timer_position;
    logic signed [31:0] timer_timeout_ms;
    logic signed [31:0] timer_elapsed_ms;
    logic               last;
  } out_item_t;

endpackage

// ===== hw/rtl/setb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setb_if: valid/ready channel
// Carries one payload struct per transfer.
// ----------------------------------------------------------------------------
interface setb_in_if;
  import setb_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface setb_out_if;
  import setb_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sorted_expiry_timer_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_expiry_timer_table: position-sorted countdown timer table
// Timers sit in one synchronous RAM (position, timeout, elapsed), sorted by
// ascending position; a sequencer walks it one entry per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   in  : one command per transfer (clear, insert, tick, dump).
//   out : status replies and timer records; last marks the final result
//         of a command.
// Timing: one command at a time; in_ch.ready is high only in idle with a
//   free output register. The walk reads entry i while it processes entry
//   i-1. Clear and a bad timeout answer the cycle after the transfer; an
//   insert scans the entries, shifts those from the slot upward up by one,
//   one entry a cycle from the top down, then puts the new entry; tick and
//   dump walk every entry, held by any output stall. Throughput is set by
//   the single RAM read port: one entry per cycle unless the output stalls.
// Reset: entry count goes to zero; RAM contents are not cleared (only
//   entries below the count are ever read).
// Stall: a full output register holds the walk; nothing is dropped. A tick
//   record waits in a hold register until the next expired timer or the end
//   of the walk decides its last flag. A tick compacts in place: survivors
//   are written back at a write index that never passes the read index.
// ----------------------------------------------------------------------------
module sorted_expiry_timer_table #(
  parameter int MAX_TIMERS = 64,
  parameter int BLOCK_EDGE = 16
) (
  input logic clk,
  input logic rst_n,
  setb_in_if.sink    in_ch,
  setb_out_if.source out_ch
);
  import setb_pkg::*;

  localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CW = $clog2(MAX_TIMERS + 1);
  // position packing round-trips for any edge; kept for the cell geometry
  localparam int CELLS = BLOCK_EDGE * BLOCK_EDGE * BLOCK_EDGE;

  typedef struct packed {
    logic [11:0]        pos;
    logic signed [31:0] tmo;
    logic signed [31:0] ela;
  } ent_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_SHIFT = 6'b000100,
    S_PUT   = 6'b001000,
    S_WALK  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  ent_t mem [MAX_TIMERS];
  ent_t rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          rd_en, wr_en;
  ent_t          wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ri_r, ri_nxt;     // next read index
  logic [CW-1:0] pi_r, pi_nxt;     // index of entry in rd_q
  logic          pv_r, pv_nxt;     // rd_q holds entry pi_r
  logic [CW-1:0] wi_r, wi_nxt;     // compaction write index / insert slot
  logic          emit_r, emit_nxt; // any record emitted this command
  in_item_t      cmd_r, cmd_nxt;
  logic          ov_r, ov_nxt;
  out_item_t     od_r, od_nxt;
  logic          hold_v_r, hold_v_nxt; // tick record waiting for its last flag
  out_item_t     hold_r, hold_nxt;
  logic          adv;                  // walk moves to the next entry

  // elapsed step with saturation
  logic signed [32:0] sum33;
  logic signed [31:0] ne;
  always_comb begin
    sum33 = {rd_q.ela[31], rd_q.ela} + $signed({17'd0, cmd_r.tick_delta_ms});
    ne    = (sum33 > 33'sd2147483647) ? 32'sh7fffffff : sum33[31:0];
  end

  logic oslot;
  assign oslot = !ov_r || out_ch.ready;

  assign in_ch.ready = (state_r == S_IDLE) && oslot;
  assign out_ch.valid = ov_r;
  assign out_ch.data  = od_r;

  function automatic out_item_t stat(input status_t s);
    out_item_t o;
    o = '0;
    o.kind = KIND_STATUS;
    o.status = s;
    o.last = 1'b1;
    return o;
  endfunction

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; ri_nxt = ri_r; pi_nxt = pi_r;
    pv_nxt = pv_r; wi_nxt = wi_r; emit_nxt = emit_r; cmd_nxt = cmd_r;
    ov_nxt = ov_r && !out_ch.ready; od_nxt = od_r;
    hold_v_nxt = hold_v_r; hold_nxt = hold_r; adv = 1'b0;
    rd_en = 1'b0; rd_addr = ri_r[AW-1:0];
    wr_en = 1'b0; wr_addr = wi_r[AW-1:0]; wr_data = rd_q;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          cmd_nxt = in_ch.data;
          ri_nxt = '0; pv_nxt = 1'b0; wi_nxt = count_r; emit_nxt = 1'b0;
          hold_v_nxt = 1'b0;
          case (op_t'(in_ch.data.operation))
            OP_CLEAR: begin
              count_nxt = '0; ov_nxt = 1'b1; od_nxt = stat(ST_OK);
            end
            OP_INSERT: begin
              if (in_ch.data.timeout_ms <= 0) begin
                ov_nxt = 1'b1; od_nxt = stat(ST_BAD_TMO);
              end else state_nxt = S_SCAN;
            end
            OP_TICK: begin
              wi_nxt = '0; state_nxt = S_WALK;
            end
            default: state_nxt = S_WALK;
          endcase
        end
      end
      S_SCAN: begin
        // compare entry pi_r; find duplicate or first larger position
        if (pv_r && rd_q.pos == cmd_r.position) begin
          if (oslot) begin
            ov_nxt = 1'b1; od_nxt = stat(ST_DUP_POS); state_nxt = S_IDLE;
          end
        end else begin
          if (pv_r && rd_q.pos > cmd_r.position && wi_r == count_r) wi_nxt = pi_r;
          if (ri_r < count_r) begin
            rd_en = 1'b1; pi_nxt = ri_r; pv_nxt = 1'b1; ri_nxt = ri_r + 1'b1;
          end else if (count_r >= CW'(MAX_TIMERS)) begin
            if (oslot) begin
              ov_nxt = 1'b1; od_nxt = stat(ST_FULL); state_nxt = S_IDLE;
            end
          end else begin
            // shift from the top: read count-1 down to slot
            ri_nxt = count_r; pv_nxt = 1'b0; state_nxt = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        // rd_q holds entry ri_r (when pv_r) to move to ri_r+1
        if (pv_r) begin
          wr_en = 1'b1; wr_addr = AW'(ri_r + 1'b1); wr_data = rd_q;
        end
        if (ri_r > wi_r) begin
          rd_en = 1'b1; rd_addr = AW'(ri_r - 1'b1);
          ri_nxt = ri_r - 1'b1; pv_nxt = 1'b1;
        end else state_nxt = S_PUT;
      end
      S_PUT: begin
        if (oslot) begin
          wr_en = 1'b1; wr_addr = wi_r[AW-1:0];
          wr_data.pos = cmd_r.position; wr_data.tmo = cmd_r.timeout_ms;
          wr_data.ela = cmd_r.start_elapsed_ms;
          count_nxt = count_r + 1'b1;
          ov_nxt = 1'b1; od_nxt = stat(ST_OK); state_nxt = S_IDLE;
        end
      end
      S_WALK: begin
        adv = 1'b1;
        if (pv_r) begin
          if (cmd_r.operation == OP_DUMP) begin
            if (oslot) begin
              ov_nxt = 1'b1; emit_nxt = 1'b1;
              od_nxt = '{KIND_TIMER, ST_OK, rd_q.pos, rd_q.tmo, rd_q.ela,
                         (pi_r + 1'b1 == count_r)};
            end else adv = 1'b0;
          end else if (ne >= rd_q.tmo) begin
            // expired: release the held record, hold this one
            if (!hold_v_r || oslot) begin
              if (hold_v_r) begin
                ov_nxt = 1'b1; od_nxt = hold_r;
              end
              hold_v_nxt = 1'b1; emit_nxt = 1'b1;
              hold_nxt = '{KIND_TIMER, ST_OK, rd_q.pos, rd_q.tmo, ne, 1'b0};
            end else adv = 1'b0;
          end else begin
            wr_en = 1'b1; wr_addr = wi_r[AW-1:0];
            wr_data.ela = ne; wi_nxt = wi_r + 1'b1;
          end
        end
        if (adv) begin
          pv_nxt = 1'b0;
          if (ri_r < count_r) begin
            rd_en = 1'b1; pi_nxt = ri_r; pv_nxt = 1'b1; ri_nxt = ri_r + 1'b1;
          end else state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (cmd_r.operation == OP_TICK) count_nxt = wi_r;
        if (hold_v_r) begin
          // final tick record goes out with last set
          if (oslot) begin
            ov_nxt = 1'b1; od_nxt = hold_r; od_nxt.last = 1'b1;
            hold_v_nxt = 1'b0; state_nxt = S_IDLE;
          end
        end else if (!emit_r) begin
          if (oslot) begin
            ov_nxt = 1'b1; od_nxt = stat(ST_OK); state_nxt = S_IDLE;
          end
        end else state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; ov_r <= 1'b0; pv_r <= 1'b0;
      emit_r <= 1'b0; hold_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; ov_r <= ov_nxt; pv_r <= pv_nxt;
      emit_r <= emit_nxt; hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; ri_r <= ri_nxt; pi_r <= pi_nxt; wi_r <= wi_nxt;
    od_r <= od_nxt; hold_r <= hold_nxt;
  end

  // ---------------------------------------------------------------- checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_TIMERS)) else $error("entry count over capacity");
  a_wi_le_ri: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && cmd_r.operation == OP_TICK) |-> (wi_r <= ri_r))
    else $error("compaction overran read");
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (state_r == S_IDLE)) else $error("ready outside idle");
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.data.operation == OP_CLEAR)
      |=> (count_r == '0)) else $error("clear left entries");
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for sorted_expiry_timer_table
// Drives commands over the input channel and compares every status reply and
// timer record against an in-bench table predictor, with random idling on
// both channels.
// ----------------------------------------------------------------------------
module tb;
  import setb_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int IDLE_LIMIT  = 20000;

  logic clk;
  logic rst_n;

  setb_in_if  in_ch ();
  setb_out_if out_ch ();

  sorted_expiry_timer_table #(
    .MAX_TIMERS(TABLE_DEPTH),
    .BLOCK_EDGE(16)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted table contents, kept sorted by position.
  logic [11:0]        tbl_pos[TABLE_DEPTH];
  logic signed [31:0] tbl_tmo[TABLE_DEPTH];
  logic signed [31:0] tbl_ela[TABLE_DEPTH];
  int                 tbl_count;

  out_item_t pending_results[$];
  int        error_count;
  int        idle_cycles;

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    error_count++;
  endtask

  function automatic out_item_t status_reply(input status_t st);
    out_item_t r;
    r = '0;
    r.kind   = KIND_STATUS;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  function automatic out_item_t timer_record(input int i, input logic signed [31:0] ela);
    out_item_t r;
    r = '0;
    r.kind             = KIND_TIMER;
    r.timer_position   = tbl_pos[i];
    r.timer_timeout_ms = tbl_tmo[i];
    r.timer_elapsed_ms = ela;
    return r;
  endfunction

  // Apply one command to the predicted table and queue its results.
  task automatic predict_command(input in_item_t cmd);
    int        at, w, first;
    bit        dup;
    longint    sum;
    logic signed [31:0] ne;
    out_item_t r;
    first = pending_results.size();
    case (op_t'(cmd.operation))
      OP_CLEAR: begin
        tbl_count = 0;
        pending_results.push_back(status_reply(ST_OK));
      end
      OP_INSERT: begin
        dup = 0;
        at  = tbl_count;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_pos[i] == cmd.position) dup = 1;
          if (tbl_pos[i] > cmd.position && at == tbl_count) at = i;
        end
        if (cmd.timeout_ms <= 0) begin
          pending_results.push_back(status_reply(ST_BAD_TMO));
        end else if (dup) begin
          pending_results.push_back(status_reply(ST_DUP_POS));
        end else if (tbl_count >= TABLE_DEPTH) begin
          pending_results.push_back(status_reply(ST_FULL));
        end else begin
          for (int i = tbl_count; i > at; i--) begin
            tbl_pos[i] = tbl_pos[i-1];
            tbl_tmo[i] = tbl_tmo[i-1];
            tbl_ela[i] = tbl_ela[i-1];
          end
          tbl_pos[at] = cmd.position;
          tbl_tmo[at] = cmd.timeout_ms;
          tbl_ela[at] = cmd.start_elapsed_ms;
          tbl_count++;
          pending_results.push_back(status_reply(ST_OK));
        end
      end
      OP_TICK: begin
        w = 0;
        for (int i = 0; i < tbl_count; i++) begin
          sum = longint'(tbl_ela[i]) + longint'(cmd.tick_delta_ms);
          ne  = (sum > 64'sd2147483647) ? 32'sh7fffffff : sum[31:0];
          if (ne >= tbl_tmo[i]) begin
            pending_results.push_back(timer_record(i, ne));
          end else begin
            tbl_pos[w] = tbl_pos[i];
            tbl_tmo[w] = tbl_tmo[i];
            tbl_ela[w] = ne;
            w++;
          end
        end
        tbl_count = w;
      end
      default: begin
        for (int i = 0; i < tbl_count; i++)
          pending_results.push_back(timer_record(i, tbl_ela[i]));
      end
    endcase
    if (pending_results.size() == first) begin
      pending_results.push_back(status_reply(ST_OK));
    end else begin
      r = pending_results[$];
      r.last = 1'b1;
      pending_results[$] = r;
    end
  endtask

  // Send one command; prediction happens at the accepting edge.
  // Valid drops only for an idle gap, so back-to-back sends never assign it
  // twice in one time step.
  task automatic send_command(input in_item_t cmd);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= cmd;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_command(cmd);
  endtask

  function automatic in_item_t make_cmd(input op_t op, input logic [11:0] pos,
                                        input logic signed [31:0] tmo,
                                        input logic signed [31:0] ela,
                                        input logic [15:0] dt);
    in_item_t c;
    c.operation = op;
    c.position = pos;
    c.timeout_ms = tmo;
    c.start_elapsed_ms = ela;
    c.tick_delta_ms = dt;
    return c;
  endfunction

  // Result side: random stall, then compare with the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.data.kind !== exp_r.kind) report_mismatch("kind");
        if (out_ch.data.status !== exp_r.status) report_mismatch("status");
        if (out_ch.data.timer_position !== exp_r.timer_position)
          report_mismatch("timer_position");
        if (out_ch.data.timer_timeout_ms !== exp_r.timer_timeout_ms)
          report_mismatch("timer_timeout_ms");
        if (out_ch.data.timer_elapsed_ms !== exp_r.timer_elapsed_ms)
          report_mismatch("timer_elapsed_ms");
        if (out_ch.data.last !== exp_r.last) report_mismatch("last");
      end
    end
  end

  // Ready is redrawn once per transfer: high, or low for a random countdown.
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        stall_left   <= $urandom_range(0, 14);
        out_ch.ready <= 1'b0;
      end
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_s32();
    return $urandom();
  endfunction

  task automatic test_directed();
    send_command(make_cmd(OP_DUMP, 12'd0, 32'sd0, 32'sd0, 16'd0));      // empty dump
    send_command(make_cmd(OP_TICK, 12'd0, 32'sd0, 32'sd0, 16'hffff));   // empty tick
    send_command(make_cmd(OP_INSERT, 12'h010, 32'sd0, 32'sd0, 16'd0));  // zero timeout
    send_command(make_cmd(OP_INSERT, 12'h010, 32'sh80000000, 32'sd0, 16'd0));
    send_command(make_cmd(OP_INSERT, 12'hfff, 32'sh7fffffff, 32'sh7fff0000, 16'd0));
    send_command(make_cmd(OP_INSERT, 12'h000, 32'sd1, 32'sh80000000, 16'd0));
    send_command(make_cmd(OP_INSERT, 12'h555, 32'sd1000, 32'sd0, 16'd0));
    send_command(make_cmd(OP_INSERT, 12'haaa, 32'sd500, 32'sd499, 16'd0));
    send_command(make_cmd(OP_INSERT, 12'h555, 32'sd7, 32'sd0, 16'd0));  // duplicate
    send_command(make_cmd(OP_DUMP, 12'hfff, 32'sd0, 32'sd0, 16'd0));
    send_command(make_cmd(OP_TICK, 12'd0, 32'sd0, 32'sd0, 16'd1));      // one expires
    send_command(make_cmd(OP_TICK, 12'd0, 32'sd0, 32'sd0, 16'hffff));   // saturates top
    send_command(make_cmd(OP_TICK, 12'd0, 32'sd0, 32'sd0, 16'hffff));
    send_command(make_cmd(OP_DUMP, 12'd0, 32'sd0, 32'sd0, 16'd0));
    send_command(make_cmd(OP_CLEAR, 12'hfff, 32'shffffffff, 32'shffffffff, 16'hffff));
    send_command(make_cmd(OP_DUMP, 12'd0, 32'sd0, 32'sd0, 16'd0));
  endtask

  // Fill the table past its capacity, then dump and drain it.
  task automatic test_table_full();
    for (int i = 0; i < TABLE_DEPTH + 2; i++)
      send_command(make_cmd(OP_INSERT,
                            12'(($urandom_range(0, 4095) & 12'hfc0) | i[5:0]),
                            $urandom_range(1, 200000), $urandom_range(0, 1000),
                            16'd0));
    send_command(make_cmd(OP_DUMP, 12'd0, 32'sd0, 32'sd0, 16'd0));
    send_command(make_cmd(OP_TICK, 12'd0, 32'sd0, 32'sd0, 16'hffff));
    send_command(make_cmd(OP_TICK, 12'd0, 32'sd0, 32'sd0, 16'hffff));
    send_command(make_cmd(OP_TICK, 12'd0, 32'sd0, 32'sd0, 16'hffff));
    send_command(make_cmd(OP_TICK, 12'd0, 32'sd0, 32'sd0, 16'hffff));
    send_command(make_cmd(OP_CLEAR, 12'd0, 32'sd0, 32'sd0, 16'd0));
  endtask

  // Mostly inserts with small timeouts and ticks, so timers really expire.
  task automatic test_random_traffic();
    int sel;
    in_item_t c;
    for (int n = 0; n < 130; n++) begin
      sel = $urandom_range(0, 99);
      c = make_cmd(OP_INSERT, 12'($urandom()), $urandom_range(1, 5000),
                   $urandom_range(0, 2000), 16'($urandom()));
      if (sel < 4) c.operation = OP_CLEAR;
      else if (sel < 30) c.operation = OP_TICK;
      else if (sel < 38) c.operation = OP_DUMP;
      else if (sel < 44) c.timeout_ms = rand_s32();
      else if (sel < 48) c.start_elapsed_ms = rand_s32();
      else if (sel < 54) c.position = 12'h0f0 | 12'($urandom_range(0, 3));
      if (c.operation == OP_TICK && $urandom_range(0, 1)) c.tick_delta_ms &= 16'h07ff;
      send_command(c);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    tbl_count = 0;
    error_count = 0;
    idle_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random_traffic();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
